>>> design/pbcr_pkg.sv
// ----------------------------------------------------------------------------
// pbcr_pkg
// Shared constants, codes and types of the page buffer clock replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package pbcr_pkg;

   localparam int NUM_FRAMES = 16;
   localparam int IDX_W      = $clog2(NUM_FRAMES);
   localparam int FRAME_W    = 6;
   localparam int KIND_W     = 3;
   localparam int FILE_W     = 8;
   localparam int PAGE_W     = 24;
   localparam int STATUS_W   = 3;
   localparam int PIN_W      = 8;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_UNPIN   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DISPOSE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ALL_PINNED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_PINNED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_PINNED     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_FRAME  = 3'd5;

   // result item types
   localparam logic ITEM_FINAL = 1'b0;
   localparam logic ITEM_WB    = 1'b1;

   localparam logic [PIN_W-1:0] PIN_MAX = 8'hFF;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SWEEP,
      S_FLUSH,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic              valid;
      logic              dirty;
      logic              refm;
      logic [PIN_W-1:0]  pin;
      logic [FILE_W-1:0] ftag;
      logic [PAGE_W-1:0] ptag;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        entry;
   } wr_type;

endpackage

`default_nettype wire

>>> design/pbcr_if.sv
// ----------------------------------------------------------------------------
// pbcr_req_if / pbcr_rsp_if
// Valid/ready channels for requests and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbcr_req_if;
   logic                          valid;
   logic                          ready;
   logic [pbcr_pkg::KIND_W-1:0]   kind;
   logic [pbcr_pkg::FILE_W-1:0]   file_id;
   logic [pbcr_pkg::PAGE_W-1:0]   page_no;
   logic                          mark_dirty;

   modport source (output valid, kind, file_id, page_no, mark_dirty, input ready);
   modport sink   (input valid, kind, file_id, page_no, mark_dirty, output ready);
endinterface

interface pbcr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          item_type;
   logic [pbcr_pkg::STATUS_W-1:0] status;
   logic [pbcr_pkg::FRAME_W-1:0]  frame;
   logic [pbcr_pkg::FILE_W-1:0]   wb_file;
   logic [pbcr_pkg::PAGE_W-1:0]   wb_page;
   logic                          load_needed;
   logic                          last;

   modport source (output valid, item_type, status, frame, wb_file, wb_page,
                   load_needed, last, input ready);
   modport sink   (input valid, item_type, status, frame, wb_file, wb_page,
                   load_needed, last, output ready);
endinterface

`default_nettype wire

>>> design/page_buffer_clock_replacement.sv
// ----------------------------------------------------------------------------
// page_buffer_clock_replacement
// Buffer pool of page frames with clock-sweep victim choice; a small sequencer
// over a single table port visits one frame per cycle unless results stall.
// ----------------------------------------------------------------------------
// Sequence: accept, then a tag search from frame 0, a clock sweep from the frame
//   after the hand on a read or allocate miss, and the final status item.
// Flush visits the frames in order and stops at a pinned frame of the file.
// Throughput: one request at a time; a stalled result output holds the sequencer.
// Reset: synchronous; all frames invalid, hand at the last frame, no result.
// ----------------------------------------------------------------------------
`default_nettype none

module page_buffer_clock_replacement (
   input  wire logic   clock,
   input  wire logic   reset,
   pbcr_req_if.sink    req_ch,
   pbcr_rsp_if.source  rsp_ch
);

   localparam logic [pbcr_pkg::IDX_W-1:0] LAST_IDX =
      pbcr_pkg::IDX_W'(pbcr_pkg::NUM_FRAMES - 1);

   pbcr_pkg::state_type state_ff, state_in;

   logic [pbcr_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [pbcr_pkg::FILE_W-1:0]   fid_ff, fid_in;
   logic [pbcr_pkg::PAGE_W-1:0]   pno_ff, pno_in;
   logic                          md_ff, md_in;
   logic [pbcr_pkg::IDX_W-1:0]    ptr_ff, ptr_in;
   logic [pbcr_pkg::IDX_W-1:0]    hand_ff, hand_in;
   logic [pbcr_pkg::IDX_W-1:0]    seen_ff, seen_in;
   logic [pbcr_pkg::STATUS_W-1:0] fst_ff, fst_in;
   logic [pbcr_pkg::IDX_W-1:0]    ffr_ff, ffr_in;
   logic                          fld_ff, fld_in;

   logic                          rv_ff, rv_in;
   logic                          rtype_ff, rtype_in;
   logic [pbcr_pkg::STATUS_W-1:0] rst_ff, rst_in;
   logic [pbcr_pkg::FRAME_W-1:0]  rfr_ff, rfr_in;
   logic [pbcr_pkg::FILE_W-1:0]   rwf_ff, rwf_in;
   logic [pbcr_pkg::PAGE_W-1:0]   rwp_ff, rwp_in;
   logic                          rld_ff, rld_in;

   pbcr_pkg::entry_type ent;
   pbcr_pkg::wr_type    wr;

   logic accept, go, match, fmatch, at_end, pinned, victim, emit_wb, emit_fin;
   logic [pbcr_pkg::IDX_W-1:0] ptr_nxt, hand_nxt;

   pbcr_frame_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (ptr_ff),
      .rd_entry (ent),
      .wr       (wr)
   );

   // decode the visited frame
   assign accept   = req_ch.valid && req_ch.ready;
   assign go       = !rv_ff || rsp_ch.ready;
   assign match    = ent.valid && (ent.ftag == fid_ff) && (ent.ptag == pno_ff);
   assign fmatch   = ent.valid && (ent.ftag == fid_ff);
   assign at_end   = (ptr_ff == LAST_IDX);
   assign pinned   = (ent.pin != '0);
   assign victim   = !ent.valid || (!ent.refm && !pinned);
   assign ptr_nxt  = at_end ? '0 : ptr_ff + 1'b1;
   assign hand_nxt = (hand_ff == LAST_IDX) ? '0 : hand_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pbcr_pkg::S_IDLE: begin
            if (accept) begin
               if (req_ch.kind == pbcr_pkg::KIND_FLUSH) state_in = pbcr_pkg::S_FLUSH;
               else if (req_ch.kind == pbcr_pkg::KIND_READ ||
                        req_ch.kind == pbcr_pkg::KIND_UNPIN ||
                        req_ch.kind == pbcr_pkg::KIND_ALLOC ||
                        req_ch.kind == pbcr_pkg::KIND_DISPOSE)
                  state_in = pbcr_pkg::S_SEARCH;
               else state_in = pbcr_pkg::S_FINAL;
            end
         end
         pbcr_pkg::S_SEARCH: begin
            if (go) begin
               if (match) state_in = pbcr_pkg::S_FINAL;
               else if (at_end) begin
                  if (kind_ff == pbcr_pkg::KIND_READ || kind_ff == pbcr_pkg::KIND_ALLOC)
                     state_in = pbcr_pkg::S_SWEEP;
                  else state_in = pbcr_pkg::S_FINAL;
               end
            end
         end
         pbcr_pkg::S_SWEEP: begin
            if (go) begin
               if (victim) state_in = pbcr_pkg::S_FINAL;
               else if (!ent.refm && seen_ff == LAST_IDX) state_in = pbcr_pkg::S_FINAL;
            end
         end
         pbcr_pkg::S_FLUSH: begin
            if (go && ((fmatch && pinned) || at_end)) state_in = pbcr_pkg::S_FINAL;
         end
         pbcr_pkg::S_FINAL: begin
            if (go) state_in = pbcr_pkg::S_IDLE;
         end
         default: state_in = pbcr_pkg::S_IDLE;
      endcase
   end

   // sequencer datapath and table writes
   always_comb begin
      kind_in  = kind_ff;
      fid_in   = fid_ff;
      pno_in   = pno_ff;
      md_in    = md_ff;
      ptr_in   = ptr_ff;
      hand_in  = hand_ff;
      seen_in  = seen_ff;
      fst_in   = fst_ff;
      ffr_in   = ffr_ff;
      fld_in   = fld_ff;
      emit_wb  = 1'b0;
      emit_fin = 1'b0;
      wr.en    = 1'b0;
      wr.addr  = ptr_ff;
      wr.entry = ent;
      unique case (state_ff)
         pbcr_pkg::S_IDLE: begin
            if (accept) begin
               kind_in = req_ch.kind;
               fid_in  = req_ch.file_id;
               pno_in  = req_ch.page_no;
               md_in   = req_ch.mark_dirty;
               ptr_in  = '0;
               fst_in  = pbcr_pkg::ST_OK;
               ffr_in  = '0;
               fld_in  = 1'b0;
            end
         end
         pbcr_pkg::S_SEARCH: begin
            if (go) begin
               if (match) begin
                  ffr_in = ptr_ff;
                  unique case (kind_ff)
                     pbcr_pkg::KIND_READ: begin
                        wr.en         = 1'b1;
                        wr.entry.refm = 1'b1;
                        if (ent.pin != pbcr_pkg::PIN_MAX) wr.entry.pin = ent.pin + 1'b1;
                     end
                     pbcr_pkg::KIND_UNPIN: begin
                        if (!pinned) fst_in = pbcr_pkg::ST_NOT_PINNED;
                        else begin
                           wr.en          = 1'b1;
                           wr.entry.pin   = ent.pin - 1'b1;
                           wr.entry.dirty = ent.dirty | md_ff;
                        end
                     end
                     pbcr_pkg::KIND_ALLOC: fst_in = pbcr_pkg::ST_BAD_FRAME;
                     default: begin
                        wr.en          = 1'b1;
                        wr.entry.valid = 1'b0;
                        wr.entry.dirty = 1'b0;
                        wr.entry.refm  = 1'b0;
                        wr.entry.pin   = '0;
                     end
                  endcase
               end else if (at_end) begin
                  ptr_in  = hand_nxt;
                  seen_in = '0;
                  if (kind_ff == pbcr_pkg::KIND_UNPIN) fst_in = pbcr_pkg::ST_NOT_FOUND;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         pbcr_pkg::S_SWEEP: begin
            if (go) begin
               hand_in = ptr_ff;
               if (victim) begin
                  emit_wb        = ent.valid && ent.dirty;
                  wr.en          = 1'b1;
                  wr.entry.valid = 1'b1;
                  wr.entry.dirty = 1'b0;
                  wr.entry.refm  = 1'b1;
                  wr.entry.pin   = pbcr_pkg::PIN_W'(1);
                  wr.entry.ftag  = fid_ff;
                  wr.entry.ptag  = pno_ff;
                  ffr_in         = ptr_ff;
                  fld_in         = (kind_ff == pbcr_pkg::KIND_READ);
               end else if (ent.refm) begin
                  wr.en         = 1'b1;
                  wr.entry.refm = 1'b0;
                  ptr_in        = ptr_nxt;
               end else begin
                  seen_in = seen_ff + 1'b1;
                  ptr_in  = ptr_nxt;
                  if (seen_ff == LAST_IDX) fst_in = pbcr_pkg::ST_ALL_PINNED;
               end
            end
         end
         pbcr_pkg::S_FLUSH: begin
            if (go) begin
               if (fmatch && pinned) begin
                  fst_in = pbcr_pkg::ST_PINNED;
                  ffr_in = ptr_ff;
               end else begin
                  if (fmatch) begin
                     emit_wb        = ent.dirty;
                     wr.en          = 1'b1;
                     wr.entry.valid = 1'b0;
                     wr.entry.dirty = 1'b0;
                     wr.entry.refm  = 1'b0;
                     wr.entry.pin   = '0;
                  end
                  if (!at_end) ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         pbcr_pkg::S_FINAL: begin
            emit_fin = go;
         end
         default: ;
      endcase
   end

   // load the result register; hold it while the sink stalls
   always_comb begin
      rv_in    = rv_ff && !rsp_ch.ready;
      rtype_in = rtype_ff;
      rst_in   = rst_ff;
      rfr_in   = rfr_ff;
      rwf_in   = rwf_ff;
      rwp_in   = rwp_ff;
      rld_in   = rld_ff;
      priority if (emit_wb) begin
         rv_in    = 1'b1;
         rtype_in = pbcr_pkg::ITEM_WB;
         rst_in   = pbcr_pkg::ST_OK;
         rfr_in   = pbcr_pkg::FRAME_W'(ptr_ff);
         rwf_in   = ent.ftag;
         rwp_in   = ent.ptag;
         rld_in   = 1'b0;
      end else if (emit_fin) begin
         rv_in    = 1'b1;
         rtype_in = pbcr_pkg::ITEM_FINAL;
         rst_in   = fst_ff;
         rfr_in   = pbcr_pkg::FRAME_W'(ffr_ff);
         rwf_in   = '0;
         rwp_in   = '0;
         rld_in   = fld_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbcr_pkg::S_IDLE;
         rv_ff    <= 1'b0;
         hand_ff  <= LAST_IDX;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         hand_ff  <= hand_in;
      end
   end

   // request and result payload registers
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      fid_ff   <= fid_in;
      pno_ff   <= pno_in;
      md_ff    <= md_in;
      ptr_ff   <= ptr_in;
      seen_ff  <= seen_in;
      fst_ff   <= fst_in;
      ffr_ff   <= ffr_in;
      fld_ff   <= fld_in;
      rtype_ff <= rtype_in;
      rst_ff   <= rst_in;
      rfr_ff   <= rfr_in;
      rwf_ff   <= rwf_in;
      rwp_ff   <= rwp_in;
      rld_ff   <= rld_in;
   end

   assign req_ch.ready       = (state_ff == pbcr_pkg::S_IDLE);
   assign rsp_ch.valid       = rv_ff;
   assign rsp_ch.item_type   = rtype_ff;
   assign rsp_ch.status      = rst_ff;
   assign rsp_ch.frame       = rfr_ff;
   assign rsp_ch.wb_file     = rwf_ff;
   assign rsp_ch.wb_page     = rwp_ff;
   assign rsp_ch.load_needed = rld_ff;
   assign rsp_ch.last        = (rtype_ff == pbcr_pkg::ITEM_FINAL);

endmodule

`default_nettype wire

>>> design/pbcr_frame_table.sv
// ----------------------------------------------------------------------------
// pbcr_frame_table
// Per-frame marks, pin counts and tags; one read and one write address.
// ----------------------------------------------------------------------------
`default_nettype none

module pbcr_frame_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [pbcr_pkg::IDX_W-1:0]     rd_addr,
   output pbcr_pkg::entry_type                 rd_entry,
   input  wire pbcr_pkg::wr_type               wr
);

   logic                          valid_ff [pbcr_pkg::NUM_FRAMES];
   logic                          dirty_ff [pbcr_pkg::NUM_FRAMES];
   logic                          refm_ff  [pbcr_pkg::NUM_FRAMES];
   logic [pbcr_pkg::PIN_W-1:0]    pin_ff   [pbcr_pkg::NUM_FRAMES];
   logic [pbcr_pkg::FILE_W-1:0]   ftag_ff  [pbcr_pkg::NUM_FRAMES];
   logic [pbcr_pkg::PAGE_W-1:0]   ptag_ff  [pbcr_pkg::NUM_FRAMES];

   // update marks and counts; clear the marks and counts of all frames on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pbcr_pkg::NUM_FRAMES; i++) begin
            valid_ff[i] <= 1'b0;
            dirty_ff[i] <= 1'b0;
            refm_ff[i]  <= 1'b0;
            pin_ff[i]   <= '0;
         end
      end else if (wr.en) begin
         valid_ff[wr.addr] <= wr.entry.valid;
         dirty_ff[wr.addr] <= wr.entry.dirty;
         refm_ff[wr.addr]  <= wr.entry.refm;
         pin_ff[wr.addr]   <= wr.entry.pin;
      end
   end

   // update tags
   always_ff @(posedge clock) begin
      if (wr.en) begin
         ftag_ff[wr.addr] <= wr.entry.ftag;
         ptag_ff[wr.addr] <= wr.entry.ptag;
      end
   end

   // read the addressed frame
   always_comb begin
      rd_entry.valid = valid_ff[rd_addr];
      rd_entry.dirty = dirty_ff[rd_addr];
      rd_entry.refm  = refm_ff[rd_addr];
      rd_entry.pin   = pin_ff[rd_addr];
      rd_entry.ftag  = ftag_ff[rd_addr];
      rd_entry.ptag  = ptag_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> design/pbcr_checker.sv
// ----------------------------------------------------------------------------
// pbcr_checker
// Port-level checks of the page buffer block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbcr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          item_type,
   input wire logic [pbcr_pkg::STATUS_W-1:0] status,
   input wire logic                          load_needed,
   input wire logic                          last
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // a write-back item is never final and carries ok
   a_wb_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && item_type) |-> (!last && !load_needed && status == pbcr_pkg::ST_OK))
      else $error("malformed write-back item");

   // a load is asked only on a final ok status
   a_load_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && load_needed) |-> (last && status == pbcr_pkg::ST_OK))
      else $error("load flag on non-final item");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind page_buffer_clock_replacement pbcr_checker u_pbcr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .item_type   (rsp_ch.item_type),
   .status      (rsp_ch.status),
   .load_needed (rsp_ch.load_needed),
   .last        (rsp_ch.last)
);

`default_nettype wire

>>> tb/pbcr_tb_if.sv
// ----------------------------------------------------------------------------
// pbcr_tb_if
// Testbench-side copy point for the request and result channel interfaces.
// ----------------------------------------------------------------------------
// The block's own interfaces (pbcr_req_if, pbcr_rsp_if) already carry the
// source and sink modports, so this file only holds a small helper package
// with the request and result records used by the stimulus table.
`default_nettype none

package pbcr_tb_pkg;

   typedef struct packed {
      logic [pbcr_pkg::KIND_W-1:0] kind;
      logic [pbcr_pkg::FILE_W-1:0] file_id;
      logic [pbcr_pkg::PAGE_W-1:0] page_no;
      logic                        mark_dirty;
   } request_type;

   typedef struct packed {
      logic                          item_type;
      logic [pbcr_pkg::STATUS_W-1:0] status;
      logic [pbcr_pkg::FRAME_W-1:0]  frame;
      logic [pbcr_pkg::FILE_W-1:0]   wb_file;
      logic [pbcr_pkg::PAGE_W-1:0]   wb_page;
      logic                          load_needed;
      logic                          last;
   } result_type;
endpackage

`default_nettype wire

>>> tb/page_buffer_clock_replacement_tb.sv
// ----------------------------------------------------------------------------
// page_buffer_clock_replacement_tb
// Drives read, unpin, allocate, dispose, flush and unknown-kind requests into the page
// buffer, mirrors the frame table and clock hand in a local predictor, and
// checks every result item in order. A directed table comes first, then
// random traffic over a small set of pages with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module page_buffer_clock_replacement_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pbcr_req_if req_ch ();
   pbcr_rsp_if rsp_ch ();

   page_buffer_clock_replacement dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor copy of the frame table
   logic                        fr_valid [pbcr_pkg::NUM_FRAMES];
   logic                        fr_dirty [pbcr_pkg::NUM_FRAMES];
   logic                        fr_ref   [pbcr_pkg::NUM_FRAMES];
   logic [pbcr_pkg::PIN_W-1:0]  fr_pin   [pbcr_pkg::NUM_FRAMES];
   logic [pbcr_pkg::FILE_W-1:0] fr_file  [pbcr_pkg::NUM_FRAMES];
   logic [pbcr_pkg::PAGE_W-1:0] fr_page  [pbcr_pkg::NUM_FRAMES];
   int                          clock_hand;

   pbcr_tb_pkg::result_type pending_results[$];
   int         error_count = 0;
   int         result_count = 0;
   int         wb_count = 0;
   int         sent_count = 0;
   bit         stim_done = 1'b0;
   bit         hold_rsp = 1'b0;

   function automatic pbcr_tb_pkg::result_type make_result(logic t,
         logic [pbcr_pkg::STATUS_W-1:0] st, int fr, logic [pbcr_pkg::FILE_W-1:0] wf,
         logic [pbcr_pkg::PAGE_W-1:0] wp, logic ld, logic lst);
      pbcr_tb_pkg::result_type r;
      r.item_type = t; r.status = st; r.frame = fr[pbcr_pkg::FRAME_W-1:0];
      r.wb_file = wf; r.wb_page = wp; r.load_needed = ld; r.last = lst;
      return r;
   endfunction

   function automatic void wipe_frame(int f);
      fr_valid[f] = 0; fr_dirty[f] = 0; fr_ref[f] = 0;
      fr_pin[f] = 0; fr_file[f] = 0; fr_page[f] = 0;
   endfunction

   function automatic void fill_frame(int f, logic [pbcr_pkg::FILE_W-1:0] fid,
                                      logic [pbcr_pkg::PAGE_W-1:0] pno);
      fr_valid[f] = 1; fr_dirty[f] = 0; fr_ref[f] = 1;
      fr_pin[f] = 1; fr_file[f] = fid; fr_page[f] = pno;
   endfunction

   function automatic int lookup_frame(logic [pbcr_pkg::FILE_W-1:0] fid,
                                       logic [pbcr_pkg::PAGE_W-1:0] pno);
      for (int i = 0; i < pbcr_pkg::NUM_FRAMES; i++)
         if (fr_valid[i] && fr_file[i] == fid && fr_page[i] == pno) return i;
      return -1;
   endfunction

   // clock sweep: returns victim or -1 when everything is pinned
   function automatic int sweep_victim();
      int pinned_seen;
      int f;
      pinned_seen = 0;
      while (pinned_seen < pbcr_pkg::NUM_FRAMES) begin
         clock_hand = (clock_hand + 1) % pbcr_pkg::NUM_FRAMES;
         f = clock_hand;
         if (!fr_valid[f]) begin
            wipe_frame(f);
            return f;
         end
         if (fr_ref[f]) begin
            fr_ref[f] = 0;
            continue;
         end
         if (fr_pin[f] > 0) begin
            pinned_seen++;
            continue;
         end
         if (fr_dirty[f])
            pending_results.push_back(make_result(pbcr_pkg::ITEM_WB, pbcr_pkg::ST_OK, f,
                                                  fr_file[f], fr_page[f], 0, 0));
         wipe_frame(f);
         return f;
      end
      return -1;
   endfunction

   // predict the result items of one accepted request
   function automatic void predict_request(pbcr_tb_pkg::request_type rq);
      int f;
      bit stopped;
      case (rq.kind)
         pbcr_pkg::KIND_READ: begin
            f = lookup_frame(rq.file_id, rq.page_no);
            if (f >= 0) begin
               fr_ref[f] = 1;
               if (fr_pin[f] != pbcr_pkg::PIN_MAX) fr_pin[f]++;
               pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL, pbcr_pkg::ST_OK,
                                                     f, 0, 0, 0, 1));
            end else begin
               f = sweep_victim();
               if (f < 0)
                  pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL,
                                                        pbcr_pkg::ST_ALL_PINNED, 0,
                                                        0, 0, 0, 1));
               else begin
                  fill_frame(f, rq.file_id, rq.page_no);
                  pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL,
                                                        pbcr_pkg::ST_OK, f, 0, 0, 1, 1));
               end
            end
         end
         pbcr_pkg::KIND_UNPIN: begin
            f = lookup_frame(rq.file_id, rq.page_no);
            if (f < 0)
               pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL,
                                                     pbcr_pkg::ST_NOT_FOUND, 0,
                                                     0, 0, 0, 1));
            else if (fr_pin[f] == 0)
               pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL,
                                                     pbcr_pkg::ST_NOT_PINNED, f,
                                                     0, 0, 0, 1));
            else begin
               fr_pin[f]--;
               if (rq.mark_dirty) fr_dirty[f] = 1;
               pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL, pbcr_pkg::ST_OK,
                                                     f, 0, 0, 0, 1));
            end
         end
         pbcr_pkg::KIND_ALLOC: begin
            f = lookup_frame(rq.file_id, rq.page_no);
            if (f >= 0)
               pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL,
                                                     pbcr_pkg::ST_BAD_FRAME, f,
                                                     0, 0, 0, 1));
            else begin
               f = sweep_victim();
               if (f < 0)
                  pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL,
                                                        pbcr_pkg::ST_ALL_PINNED, 0,
                                                        0, 0, 0, 1));
               else begin
                  fill_frame(f, rq.file_id, rq.page_no);
                  pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL,
                                                        pbcr_pkg::ST_OK, f, 0, 0, 0, 1));
               end
            end
         end
         pbcr_pkg::KIND_DISPOSE: begin
            f = lookup_frame(rq.file_id, rq.page_no);
            if (f >= 0) wipe_frame(f);
            pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL, pbcr_pkg::ST_OK,
                                                  (f >= 0) ? f : 0, 0, 0, 0, 1));
         end
         pbcr_pkg::KIND_FLUSH: begin
            stopped = 0;
            for (int i = 0; i < pbcr_pkg::NUM_FRAMES && !stopped; i++) begin
               if (!fr_valid[i] || fr_file[i] != rq.file_id) continue;
               if (fr_pin[i] > 0) begin
                  pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL,
                                                        pbcr_pkg::ST_PINNED, i,
                                                        0, 0, 0, 1));
                  stopped = 1;
               end else begin
                  if (fr_dirty[i])
                     pending_results.push_back(make_result(pbcr_pkg::ITEM_WB,
                                                           pbcr_pkg::ST_OK, i, fr_file[i],
                                                           fr_page[i], 0, 0));
                  wipe_frame(i);
               end
            end
            if (!stopped)
               pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL, pbcr_pkg::ST_OK,
                                                     0, 0, 0, 0, 1));
         end
         default:
            pending_results.push_back(make_result(pbcr_pkg::ITEM_FINAL, pbcr_pkg::ST_OK,
                                                  0, 0, 0, 0, 1));
      endcase
   endfunction

   // directed table; chk marks rows whose final item is typed in
   typedef struct {
      pbcr_tb_pkg::request_type rq;
      bit                       chk;
      pbcr_tb_pkg::result_type  exp;
   } directed_row_type;

   directed_row_type directed_table[$];

   function automatic void add_row(logic [pbcr_pkg::KIND_W-1:0] k,
                                   logic [pbcr_pkg::FILE_W-1:0] fid,
                                   logic [pbcr_pkg::PAGE_W-1:0] pno, logic d, bit chk,
                                   logic [pbcr_pkg::STATUS_W-1:0] st, int fr, logic ld);
      directed_row_type r;
      r.rq.kind = k; r.rq.file_id = fid; r.rq.page_no = pno; r.rq.mark_dirty = d;
      r.chk = chk;
      r.exp = make_result(pbcr_pkg::ITEM_FINAL, st, fr, 0, 0, ld, 1);
      directed_table.push_back(r);
   endfunction

   function automatic void build_directed();
      // after reset the hand moves to frame 0 first
      add_row(pbcr_pkg::KIND_UNPIN,   8'h00, 24'h000000, 0, 1, pbcr_pkg::ST_NOT_FOUND, 0, 0);
      add_row(pbcr_pkg::KIND_READ,    8'hFF, 24'hFFFFFF, 0, 1, pbcr_pkg::ST_OK,        0, 1);
      add_row(pbcr_pkg::KIND_READ,    8'hFF, 24'hFFFFFF, 0, 1, pbcr_pkg::ST_OK,        0, 0);
      add_row(pbcr_pkg::KIND_ALLOC,   8'hFF, 24'hFFFFFF, 0, 1, pbcr_pkg::ST_BAD_FRAME, 0, 0);
      add_row(pbcr_pkg::KIND_ALLOC,   8'h00, 24'h000000, 0, 1, pbcr_pkg::ST_OK,        1, 0);
      add_row(pbcr_pkg::KIND_UNPIN,   8'h00, 24'h000000, 1, 1, pbcr_pkg::ST_OK,        1, 0);
      add_row(pbcr_pkg::KIND_UNPIN,   8'h00, 24'h000000, 0, 1, pbcr_pkg::ST_NOT_PINNED, 1, 0);
      add_row(pbcr_pkg::KIND_READ,    8'h00, 24'h000000, 0, 0, pbcr_pkg::ST_OK, 0, 0);
      add_row(pbcr_pkg::KIND_FLUSH,   8'h00, 24'h000000, 0, 1, pbcr_pkg::ST_PINNED,    1, 0);
      add_row(pbcr_pkg::KIND_UNPIN,   8'h00, 24'h000000, 1, 0, pbcr_pkg::ST_OK, 0, 0);
      add_row(pbcr_pkg::KIND_FLUSH,   8'h00, 24'h000000, 0, 0, pbcr_pkg::ST_OK, 0, 0);
      add_row(pbcr_pkg::KIND_DISPOSE, 8'h12, 24'h345678, 0, 1, pbcr_pkg::ST_OK,        0, 0);
      add_row(pbcr_pkg::KIND_DISPOSE, 8'hFF, 24'hFFFFFF, 0, 1, pbcr_pkg::ST_OK,        0, 0);
      add_row(3'd5,                   8'hA5, 24'h5A5A5A, 1, 1, pbcr_pkg::ST_OK,        0, 0);
      add_row(3'd6,                   8'h5A, 24'hA5A5A5, 0, 1, pbcr_pkg::ST_OK,        0, 0);
      add_row(3'd7,                   8'hFF, 24'hFFFFFF, 1, 1, pbcr_pkg::ST_OK,        0, 0);
      // fill every frame pinned, then a miss finds all pinned
      for (int i = 0; i < pbcr_pkg::NUM_FRAMES; i++)
         add_row(pbcr_pkg::KIND_ALLOC, 8'h40, 24'(i), 0, 0, pbcr_pkg::ST_OK, 0, 0);
      add_row(pbcr_pkg::KIND_READ, 8'h41, 24'h000001, 0, 1, pbcr_pkg::ST_ALL_PINNED, 0, 0);
   endfunction

   // request driver; valid stays up when the next request follows at once
   task automatic send_request(pbcr_tb_pkg::request_type rq);
      int gap;
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= rq.kind;
      req_ch.file_id    <= rq.file_id;
      req_ch.page_no    <= rq.page_no;
      req_ch.mark_dirty <= rq.mark_dirty;
      do @(posedge clock); while (!req_ch.ready);
      predict_request(rq);
      sent_count++;
   endtask

   // random request over a small page pool so hits, pins and flushes happen
   function automatic pbcr_tb_pkg::request_type random_request();
      pbcr_tb_pkg::request_type rq;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      rq.kind = pbcr_pkg::KIND_READ;
      else if (pick < 70) rq.kind = pbcr_pkg::KIND_UNPIN;
      else if (pick < 80) rq.kind = pbcr_pkg::KIND_ALLOC;
      else if (pick < 88) rq.kind = pbcr_pkg::KIND_DISPOSE;
      else if (pick < 96) rq.kind = pbcr_pkg::KIND_FLUSH;
      else                rq.kind = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 19) == 0) begin
         rq.file_id = 8'($urandom);
         rq.page_no = 24'($urandom);
      end else begin
         rq.file_id = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
         rq.file_id = rq.file_id ^ 8'($urandom_range(0, 2));
         rq.page_no = ($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF;
         rq.page_no = rq.page_no ^ 24'($urandom_range(0, 9));
      end
      rq.mark_dirty = 1'($urandom);
      return rq;
   endfunction

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      directed_row_type         row;
      pbcr_tb_pkg::request_type rq;
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= pbcr_pkg::KIND_READ;
      req_ch.file_id    <= '0;
      req_ch.page_no    <= '0;
      req_ch.mark_dirty <= 1'b0;
      for (int i = 0; i < pbcr_pkg::NUM_FRAMES; i++) wipe_frame(i);
      clock_hand = pbcr_pkg::NUM_FRAMES - 1;
      build_directed();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: typed-in finals checked against the predictor too
      foreach (directed_table[i]) begin
         row = directed_table[i];
         send_request(row.rq);
         if (row.chk) begin
            pbcr_tb_pkg::result_type p;
            p = pending_results[$];
            if (p != row.exp) begin
               $display("%0t directed row %0d: expected status %0d frame %0d load %0d",
                        $time, i, row.exp.status, row.exp.frame, row.exp.load_needed);
               $display("%0t directed row %0d: actual   status %0d frame %0d load %0d",
                        $time, i, p.status, p.frame, p.load_needed);
               error_count++;
            end
         end
      end
      // release the pinned frames
      for (int i = 0; i < pbcr_pkg::NUM_FRAMES; i++) begin
         rq.kind = pbcr_pkg::KIND_UNPIN; rq.file_id = 8'h40; rq.page_no = 24'(i);
         rq.mark_dirty = 1'(i);
         send_request(rq);
      end
      req_ch.valid <= 1'b0;
      wait_drained();

      // random part; a long receiver stall partway through
      for (int n = 0; n < 400; n++) begin
         if (n == 130) hold_rsp = 1'b1;
         if (n == 270) begin
            req_ch.valid <= 1'b0;
            wait_drained();
         end
         send_request(random_request());
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // result receiver
   initial begin
      pbcr_tb_pkg::result_type exp;
      int stall;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         result_count++;
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: type %0d status %0d frame %0d", $time,
                     rsp_ch.item_type, rsp_ch.status, rsp_ch.frame);
            error_count++;
         end else begin
            exp = pending_results.pop_front();
            if (exp.item_type == pbcr_pkg::ITEM_WB) wb_count++;
            if (rsp_ch.item_type !== exp.item_type || rsp_ch.status !== exp.status ||
                rsp_ch.frame !== exp.frame || rsp_ch.wb_file !== exp.wb_file ||
                rsp_ch.wb_page !== exp.wb_page ||
                rsp_ch.load_needed !== exp.load_needed || rsp_ch.last !== exp.last) begin
               $display("%0t mismatch: expected type %0d st %0d fr %0d wb %h/%h ld %0d last %0d",
                        $time, exp.item_type, exp.status, exp.frame, exp.wb_file,
                        exp.wb_page, exp.load_needed, exp.last);
               $display("%0t          actual   type %0d st %0d fr %0d wb %h/%h ld %0d last %0d",
                        $time, rsp_ch.item_type, rsp_ch.status, rsp_ch.frame,
                        rsp_ch.wb_file, rsp_ch.wb_page, rsp_ch.load_needed, rsp_ch.last);
               error_count++;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d requests, %0d result items of which %0d write-backs.",
               sent_count, result_count, wb_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // timeout
   initial begin
      #40000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
